>>> design/prefix_preserving_ip_anonymizer_assert.svh
// Assertion macros for the prefix-preserving anonymizer checker.
// Used by the checker file; needs clk and arst_n in scope.
`ifndef PREFIX_PRESERVING_IP_ANONYMIZER_ASSERT_SVH
`define PREFIX_PRESERVING_IP_ANONYMIZER_ASSERT_SVH
// same-cycle implication
`define PPIA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PPIA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> design/ppia_pkg.sv
// Package for the prefix-preserving anonymizer: AES-128 tables and round functions.
// No dependencies.
`timescale 1ns / 1ps
package ppia_pkg;

	localparam int NumRounds = 10;
	localparam int NumPrefix = 32;

	typedef enum logic [1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW  = 2'd1,
		REG_PAD_HIGH = 2'd2,
		REG_PAD_LOW  = 2'd3
	} reg_idx_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
		8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
		8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
		8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
		8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
		8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
		8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
		8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
		8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
		8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
		8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
		8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
		8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
		8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
		8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
		8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
		8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [NumRounds] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] r;
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[c*4+i] = SBOX[s[127 - 8*(((c+i)&3)*4+i) -: 8]];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[c*4]   = a0 ^ all ^ xtime(a0 ^ a1);
				t[c*4+1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[c*4+2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[c*4+3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[127 - 8*i -: 8] = t[i];
		end
		return r;
	endfunction

	function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] t, w0, w1, w2, w3;
		t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

>>> design/prefix_preserving_ip_anonymizer.sv
// Top level of the prefix-preserving IPv4 anonymizer.
// Depends on ppia_pkg, ppia_cell and ppia_keycell.
//
// Usage:
// Input channel in_valid/in_ready carries one address per item; output channel
// out_valid/out_ready carries the anonymized address. Configuration registers
// (key_high, key_low, pad_high, pad_low at indexes 0..3) are written through
// cfg_we/cfg_index/cfg_data while no item is in flight; the user must keep to
// this, as the block does not enforce it. Each address feeds 32 lanes, one per
// prefix length; each lane is a row of 10 round cells, and a row of 10 key
// cells supplies the round keys. Throughput: one item per cycle while the
// receiver does not stall, set by the fully pipelined round cells. A new key
// settles through the key cells after the write. Reset zeroes the config and
// valid registers and so empties the pipeline; data registers are not reset.
// When the receiver stalls, the whole pipeline holds and in_ready drops.
`timescale 1ns / 1ps
module prefix_preserving_ip_anonymizer import ppia_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] anonymized_address,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	localparam int Depth = NumRounds + 2;

	logic [63:0]  key_high_q, key_low_q, pad_high_q, pad_low_q;
	logic         en;
	logic         vld_q [Depth];
	logic [31:0]  addr_q [Depth];
	logic [127:0] rk [NumRounds + 1];
	logic [127:0] st_q [NumPrefix][NumRounds + 1];
	logic [31:0]  otp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			pad_high_q <= '0;
			pad_low_q  <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_PAD_HIGH: pad_high_q <= cfg_data;
				REG_PAD_LOW:  pad_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !vld_q[Depth-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < Depth; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < Depth; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_q[0] <= address;
			for (int k = 1; k < Depth; k++) addr_q[k] <= addr_q[k-1];
		end
	end

	assign rk[0] = {key_high_q, key_low_q};

	for (genvar r = 1; r <= NumRounds; r++) begin : g_key
		ppia_keycell u_key (
			.clk    (clk),
			.rcon   (RCON[r-1]),
			.key_in (rk[r-1]),
			.key_q  (rk[r])
		);
	end

	for (genvar p = 0; p < NumPrefix; p++) begin : g_lane
		localparam logic [31:0] Mask = (p == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - p));
		logic [31:0] word;
		assign word = (addr_q[0] & Mask) | (pad_high_q[63:32] & ~Mask);

		always_ff @(posedge clk) begin
			if (en) begin
				st_q[p][0] <= {word, pad_high_q[31:0], pad_low_q} ^ rk[0];
			end
		end

		for (genvar r = 1; r <= NumRounds; r++) begin : g_round
			ppia_cell u_cell (
				.clk         (clk),
				.en          (en),
				.final_round (r == NumRounds),
				.state_in    (st_q[p][r-1]),
				.rkey        (rk[r]),
				.state_q     (st_q[p][r])
			);
		end

		assign otp[31-p] = st_q[p][NumRounds][127];
	end

	assign out_valid          = vld_q[Depth-1];
	assign anonymized_address = addr_q[Depth-1] ^ otp;
endmodule

>>> design/ppia_cell.sv
// One AES round stage of a lane: round function and pipeline register.
// Depends on ppia_pkg.
`timescale 1ns / 1ps
module ppia_cell import ppia_pkg::*; (
	input  logic         clk,
	input  logic         en,
	input  logic         final_round,
	input  logic [127:0] state_in,
	input  logic [127:0] rkey,
	output logic [127:0] state_q
);
	always_ff @(posedge clk) begin
		if (en) begin
			state_q <= aes_round(state_in, final_round) ^ rkey;
		end
	end
endmodule

>>> design/ppia_keycell.sv
// One step of the AES-128 key schedule, recomputed every cycle from its neighbor.
// Depends on ppia_pkg.
`timescale 1ns / 1ps
module ppia_keycell import ppia_pkg::*; (
	input  logic         clk,
	input  logic [7:0]   rcon,
	input  logic [127:0] key_in,
	output logic [127:0] key_q
);
	always_ff @(posedge clk) begin
		key_q <= key_step(key_in, rcon);
	end
endmodule

>>> design/ppia_checker.sv
// Port-level checker for the prefix-preserving anonymizer, bound to the top level.
// Depends on prefix_preserving_ip_anonymizer_assert.svh.
`timescale 1ns / 1ps
`include "prefix_preserving_ip_anonymizer_assert.svh"
module ppia_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] anonymized_address
);
	logic stall;
	assign stall = out_valid && !out_ready;

	`PPIA_ASSERT_NXT(a_out_hold, stall, out_valid && $stable(anonymized_address), "held item changed")
	`PPIA_ASSERT_IMP(a_ready_free, !stall, in_ready, "input stalled with output free")
	`PPIA_ASSERT_IMP(a_ready_stall, stall, !in_ready, "input taken while output stalled")
	`PPIA_ASSERT_IMP(a_out_leave, $fell(out_valid), $past(out_ready), "item left without handshake")
endmodule

bind prefix_preserving_ip_anonymizer ppia_checker u_ppia_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_ready           (in_ready),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.anonymized_address (anonymized_address)
);

>>> test/prefix_preserving_ip_anonymizer_tb.sv
// Self-checking testbench for the prefix-preserving IPv4 anonymizer.
// Predicts each anonymized address with its own AES-128 model; needs ppia_pkg and the RTL.
`timescale 1ns / 1ps
module prefix_preserving_ip_anonymizer_tb;
	import ppia_pkg::*;

	localparam int KeySettle = 16;
	localparam int DrainCycles = 40;
	localparam longint CycleLimit = 400000;

	class anon_scoreboard;
		logic [63:0] key_hi, key_lo, pad_hi, pad_lo;
		logic [31:0] pending_q[$];
		int errors;

		function new();
			key_hi = '0; key_lo = '0; pad_hi = '0; pad_lo = '0; errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [63:0] val);
			case (idx)
				REG_KEY_HIGH: key_hi = val;
				REG_KEY_LOW: key_lo = val;
				REG_PAD_HIGH: pad_hi = val;
				REG_PAD_LOW: pad_lo = val;
				default: ;
			endcase
		endfunction

		function logic [7:0] gmul2(logic [7:0] x);
			return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
		endfunction

		function logic [127:0] encrypt(logic [127:0] blk);
			logic [127:0] rk [11];
			logic [127:0] st;
			logic [7:0] sb [16];
			logic [7:0] a0, a1, a2, a3, x;
			logic [31:0] t, w0, w1, w2, w3;
			logic [7:0] rc;
			rk[0] = {key_hi, key_lo};
			rc = 8'h01;
			for (int r = 1; r <= 10; r++) begin
				t = {SBOX[rk[r-1][23:16]] ^ rc, SBOX[rk[r-1][15:8]],
					SBOX[rk[r-1][7:0]], SBOX[rk[r-1][31:24]]};
				w0 = rk[r-1][127:96] ^ t;
				w1 = rk[r-1][95:64] ^ w0;
				w2 = rk[r-1][63:32] ^ w1;
				w3 = rk[r-1][31:0] ^ w2;
				rk[r] = {w0, w1, w2, w3};
				rc = gmul2(rc);
			end
			st = blk ^ rk[0];
			for (int r = 1; r <= 10; r++) begin
				for (int c = 0; c < 4; c++)
					for (int i = 0; i < 4; i++)
						sb[c*4+i] = SBOX[st[127 - 8*(((c+i)&3)*4+i) -: 8]];
				if (r < 10) begin
					for (int c = 0; c < 4; c++) begin
						a0 = sb[c*4]; a1 = sb[c*4+1]; a2 = sb[c*4+2]; a3 = sb[c*4+3];
						x = a0 ^ a1 ^ a2 ^ a3;
						sb[c*4] = a0 ^ x ^ gmul2(a0 ^ a1);
						sb[c*4+1] = a1 ^ x ^ gmul2(a1 ^ a2);
						sb[c*4+2] = a2 ^ x ^ gmul2(a2 ^ a3);
						sb[c*4+3] = a3 ^ x ^ gmul2(a3 ^ a0);
					end
				end
				for (int i = 0; i < 16; i++)
					st[127 - 8*i -: 8] = sb[i];
				st = st ^ rk[r];
			end
			return st;
		endfunction

		function logic [31:0] anonymize(logic [31:0] addr);
			logic [31:0] mask, otp;
			logic [127:0] blk, ct;
			otp = '0;
			for (int p = 0; p < 32; p++) begin
				mask = (p == 0) ? 32'h0 : (32'hffff_ffff << (32 - p));
				blk = {(addr & mask) | (pad_hi[63:32] & ~mask), pad_hi[31:0], pad_lo};
				ct = encrypt(blk);
				otp[31-p] = ct[127];
			end
			return addr ^ otp;
		endfunction

		function void note_input(logic [31:0] addr);
			pending_q.push_back(anonymize(addr));
		endfunction

		function bit check(logic [31:0] got, output logic [31:0] want);
			if (pending_q.size() == 0) begin
				want = '0;
				return 1'b0;
			end
			want = pending_q.pop_front();
			return got === want;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [31:0] address = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] anonymized_address;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off = 0;
	longint cycles = 0;
	logic [31:0] expected;
	anon_scoreboard board = new();

	always #4 clk = ~clk;

	prefix_preserving_ip_anonymizer dut (.*);

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		board.errors++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (!board.check(anonymized_address, expected))
				report("anonymized_address", anonymized_address, expected);
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.pending_q.size() != 0)
			@(posedge clk);
		repeat (KeySettle) @(posedge clk);
	endtask

	task automatic load_config(logic [63:0] kh, logic [63:0] kl, logic [63:0] ph,
		logic [63:0] pl);
		wait_idle();
		write_reg(REG_KEY_HIGH, kh);
		write_reg(REG_KEY_LOW, kl);
		write_reg(REG_PAD_HIGH, ph);
		write_reg(REG_PAD_LOW, pl);
		cfg_we <= 1'b0;
		repeat (KeySettle) @(posedge clk);
	endtask

	task automatic send_address(logic [31:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		address <= addr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_input(addr);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [31:0] rand_address(logic [31:0] base);
		int share;
		share = $urandom_range(32);
		case ($urandom_range(3))
			0: return $urandom();
			default: return (share == 0) ? $urandom() :
				((base & (32'hffff_ffff << (32 - share))) |
				($urandom() & ~(32'hffff_ffff << (32 - share))));
		endcase
	endfunction

	task automatic random_phase(int count);
		logic [31:0] base;
		base = $urandom();
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(15) == 0)
				base = $urandom();
			send_address(rand_address(base));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (KeySettle) @(posedge clk);

		// directed: zero key and pad, extremes and prefix walks
		send_address(32'h0000_0000);
		send_address(32'hffff_ffff);
		send_address(32'h8000_0000);
		send_address(32'h0000_0001);
		send_address(32'h7fff_ffff);
		send_address(32'haaaa_aaaa);
		send_address(32'h5555_5555);
		load_config(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
			64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
		send_address(32'h0000_0000);
		send_address(32'hffff_ffff);
		send_address(32'hc0a8_0001);
		send_address(32'hc0a8_0002);
		load_config(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c,
			64'h0f0e_0d0c_0b0a_0908, 64'h0706_0504_0302_0100);
		for (int i = 0; i < 8; i++)
			send_address(32'hc0a8_0100 | (32'h1 << (i * 4)));
		// ignored register index is not reachable: cfg_index is two bits wide

		send_idle_pct = 18;
		recv_idle_pct = 76;
		load_config(rand64(), rand64(), rand64(), rand64());
		random_phase(600);

		// long receiver hold-off while the sender keeps offering
		hold_off = 300;
		random_phase(100);

		send_idle_pct = 76;
		recv_idle_pct = 18;
		load_config(rand64(), rand64(), rand64(), rand64());
		random_phase(300);
		wait_idle();
		random_phase(200);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_config(rand64(), rand64(), 64'h0, 64'hffff_ffff_ffff_ffff);
		random_phase(350);
		load_config(rand64(), rand64(), rand64(), rand64());
		random_phase(350);

		in_valid <= 1'b0;
		while (board.pending_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
